@@ sv/tsh_pkg.sv @@
// types and constants shared by the thermostat setpoint and heat controller
package tsh_pkg;

    localparam int LED_COUNT    = 10;
    localparam int SPAN         = 125;
    localparam int SETPOINT_MAX = 127;

    // gap = setpoint - temperature covers -2047 .. 2175
    localparam int GAP_W = 13;
    localparam int NUM_W = $clog2(SPAN * LED_COUNT + LED_COUNT * (1 << GAP_W)) + 2;
    localparam int CNT_W = $clog2(LED_COUNT + 1);

    localparam logic [7:0] DUTY_HIGH_RST = 8'd87;
    localparam logic [7:0] DUTY_MID_RST  = 8'd48;
    localparam logic [7:0] DUTY_LOW_RST  = 8'd24;

    typedef enum logic [1:0] {
        CMD_DIGIT,
        CMD_ERASE,
        CMD_MODE,
        CMD_SAMPLE
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_DUTY_HIGH,
        CFG_DUTY_MID,
        CFG_DUTY_LOW
    } t_cfg_idx;

    typedef struct packed {
        t_cmd               cmd;
        logic [3:0]         key_digit;
        logic signed [11:0] temperature;
    } t_in_item;

    typedef struct packed {
        logic       mode;
        logic [6:0] setpoint;
        logic [3:0] led_count;
        logic       pwm_on;
        logic [7:0] pwm_duty;
        logic       outputs_updated;
    } t_out_item;

endpackage

@@ sv/thermostat_setpoint_heat_control.sv @@
// thermostat controller: keypad setpoint entry and heat mode LED bar and PWM tier
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  input    | in        | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  result   | out       | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one item per cycle sustained while results are taken; each item is held in the input register
// and its result is then registered in the result register as the item advances
// the state update is one combinational pass between those two registers
// synchronous active-low reset clears control state and loads the duty defaults
// a stalled result holds the pipe; the input register still takes an item while empty
// config writes are always accepted
module thermostat_setpoint_heat_control
    import tsh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam logic signed [NUM_W-1:0] NUM_BASE  = NUM_W'(SPAN * LED_COUNT);
    localparam logic signed [NUM_W-1:0] NUM_SCALE = NUM_W'(LED_COUNT);
    localparam logic signed [GAP_W-1:0] GAP_HALF  = GAP_W'(SPAN / 2);
    localparam logic signed [GAP_W-1:0] GAP_QUART = GAP_W'(SPAN / 4);

    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [7:0]         r_duty_high;
    logic [7:0]         r_duty_mid;
    logic [7:0]         r_duty_low;

    logic               r_mode;
    logic [6:0]         r_setpoint;
    logic signed [11:0] r_last_temp;
    logic               r_mode_changed;
    logic [3:0]         r_led_count;
    logic               r_pwm_on;
    logic [7:0]         r_pwm_duty;

    logic               n_mode;
    logic [6:0]         n_setpoint;
    logic signed [11:0] n_last_temp;
    logic               n_mode_changed;
    logic [3:0]         n_led_count;
    logic               n_pwm_on;
    logic [7:0]         n_pwm_duty;
    logic               n_updated;

    logic               w_advance;
    logic [10:0]        w_digit_sum;
    logic [14:0]        w_div10_prod;
    logic signed [GAP_W-1:0] w_gap;
    logic signed [NUM_W-1:0] w_gap_ext;
    logic signed [NUM_W-1:0] w_num;
    logic [CNT_W-1:0]   w_leds;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_digit_sum  = {4'b0, r_setpoint} * 11'd10 + {7'b0, r_in.key_digit};
    // divide by ten as multiply by 205 and shift, exact below 1029
    assign w_div10_prod = {8'b0, r_setpoint} * 15'd205;

    assign w_gap     = $signed({{(GAP_W - 7){1'b0}}, r_setpoint})
                     - $signed({{(GAP_W - 12){r_in.temperature[11]}}, r_in.temperature});
    assign w_gap_ext = NUM_W'(w_gap);
    assign w_num     = NUM_BASE - NUM_SCALE * w_gap_ext;

    // floor(num / SPAN) clamped to 0..LED_COUNT as a count of threshold hits
    always_comb begin
        w_leds = '0;
        for (int k = 1; k <= LED_COUNT; k++) begin
            if (w_num >= $signed(NUM_W'(k * SPAN))) begin
                w_leds = w_leds + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_mode         = r_mode;
        n_setpoint     = r_setpoint;
        n_last_temp    = r_last_temp;
        n_mode_changed = r_mode_changed;
        n_led_count    = r_led_count;
        n_pwm_on       = r_pwm_on;
        n_pwm_duty     = r_pwm_duty;
        n_updated      = 1'b0;
        unique case (r_in.cmd)
            CMD_DIGIT: begin
                if (!r_mode && r_in.key_digit <= 4'd9
                        && w_digit_sum <= 11'(SPAN)
                        && w_digit_sum <= 11'(SETPOINT_MAX)) begin
                    n_setpoint = w_digit_sum[6:0];
                end
            end
            CMD_ERASE: begin
                if (!r_mode) begin
                    n_setpoint = 7'(w_div10_prod[14:11]);
                end
            end
            CMD_MODE: begin
                if (r_mode) begin
                    n_pwm_on    = 1'b0;
                    n_led_count = '0;
                    n_mode      = 1'b0;
                end else begin
                    n_mode = 1'b1;
                end
                n_mode_changed = 1'b1;
            end
            CMD_SAMPLE: begin
                if (r_mode && (r_in.temperature != r_last_temp || r_mode_changed)) begin
                    n_led_count = 4'(w_leds);
                    if (w_gap >= GAP_HALF) begin
                        n_pwm_duty = r_duty_high;
                        n_pwm_on   = 1'b1;
                    end else if (w_gap >= GAP_QUART) begin
                        n_pwm_duty = r_duty_mid;
                        n_pwm_on   = 1'b1;
                    end else if (w_gap <= $signed(GAP_W'(0))) begin
                        n_pwm_duty = '0;
                        n_pwm_on   = 1'b0;
                    end else begin
                        n_pwm_duty = r_duty_low;
                        n_pwm_on   = 1'b1;
                    end
                    n_last_temp    = r_in.temperature;
                    n_mode_changed = 1'b0;
                    n_updated      = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_duty_high    <= DUTY_HIGH_RST;
            r_duty_mid     <= DUTY_MID_RST;
            r_duty_low     <= DUTY_LOW_RST;
            r_mode         <= 1'b0;
            r_setpoint     <= '0;
            r_last_temp    <= '0;
            r_mode_changed <= 1'b1;
            r_led_count    <= '0;
            r_pwm_on       <= 1'b0;
            r_pwm_duty     <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DUTY_HIGH: r_duty_high <= i_cfg_data;
                    CFG_DUTY_MID:  r_duty_mid  <= i_cfg_data;
                    CFG_DUTY_LOW:  r_duty_low  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid    <= 1'b1;
                r_mode         <= n_mode;
                r_setpoint     <= n_setpoint;
                r_last_temp    <= n_last_temp;
                r_mode_changed <= n_mode_changed;
                r_led_count    <= n_led_count;
                r_pwm_on       <= n_pwm_on;
                r_pwm_duty     <= n_pwm_duty;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out.mode            <= n_mode;
            r_out.setpoint        <= n_setpoint;
            r_out.led_count       <= n_led_count;
            r_out.pwm_on          <= n_pwm_on;
            r_out.pwm_duty        <= n_pwm_duty;
            r_out.outputs_updated <= n_updated;
        end
    end

endmodule

@@ sv/tsh_checker.sv @@
// port-level checks for the thermostat controller and their bind
module tsh_checker
    import tsh_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out_item  o_out_data
);

    // a result waiting to be taken stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // input mode never shows a lit bar or a running heater
    a_input_mode_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.mode |-> !o_out_data.pwm_on
            && o_out_data.led_count == 4'd0)
        else $error("heater or bar active in input mode");

    a_update_in_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.outputs_updated |-> o_out_data.mode)
        else $error("update reported outside heat mode");

    a_led_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.led_count <= 4'(LED_COUNT))
        else $error("led count above bar length");

    // a fresh update that switches the heater off selects zero duty
    a_off_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.outputs_updated && !o_out_data.pwm_on
            |-> o_out_data.pwm_duty == 8'd0)
        else $error("heater off with nonzero duty");

endmodule

bind thermostat_setpoint_heat_control tsh_checker u_tsh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
